/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for checker modules
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define HKD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define HKD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* src/hkd_pkg.sv */
// ---------------------------------------------------------------------------
// hkd_pkg
// types and constants for the boot keyboard report differ
// ---------------------------------------------------------------------------
package hkd_pkg;

   localparam int SLOT_COUNT  = 6;
   localparam int MOD_COUNT   = 8;
   localparam int EVENT_COUNT = MOD_COUNT + 2 * SLOT_COUNT;
   localparam int REL_BASE    = MOD_COUNT;
   localparam int PRS_BASE    = MOD_COUNT + SLOT_COUNT;

   localparam logic [6:0] REPORT_BYTES = 7'd8;
   localparam logic [7:0] MIN_KEY_CODE = 8'd4;

   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // modifier bits are reported in this order
   localparam logic [2:0] MOD_ORDER [MOD_COUNT] = '{
      3'd0, 3'd4, 3'd1, 3'd5, 3'd2, 3'd6, 3'd3, 3'd7
   };

   typedef logic [SLOT_COUNT-1:0][7:0] slot_row_type;

   typedef struct packed {
      logic [EVENT_COUNT-1:0] mask;
      logic [7:0]             mods;
      slot_row_type           old_slots;
      slot_row_type           new_slots;
   } hkd_entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } hkd_fifo_stat_type;

endpackage

/* src/hkd_if.sv */
// ---------------------------------------------------------------------------
// hkd channel interfaces
// report and event channels with valid/ready handshake
// ---------------------------------------------------------------------------
interface hkd_req_if;
   logic       valid;
   logic       ready;
   logic [6:0] report_length;
   logic [7:0] modifier_bits;
   logic [7:0] slot_0;
   logic [7:0] slot_1;
   logic [7:0] slot_2;
   logic [7:0] slot_3;
   logic [7:0] slot_4;
   logic [7:0] slot_5;

   modport source (output valid, report_length, modifier_bits,
                   slot_0, slot_1, slot_2, slot_3, slot_4, slot_5,
                   input ready);
   modport sink (input valid, report_length, modifier_bits,
                 slot_0, slot_1, slot_2, slot_3, slot_4, slot_5,
                 output ready);
endinterface

interface hkd_rsp_if;
   logic       valid;
   logic       ready;
   logic       is_modifier;
   logic [7:0] event_code;
   logic       pressed;
   logic       last_event;

   modport source (output valid, is_modifier, event_code, pressed, last_event,
                   input ready);
   modport sink (input valid, is_modifier, event_code, pressed, last_event,
                 output ready);
endinterface

/* src/hkd_front.sv */
// ---------------------------------------------------------------------------
// hkd_front
// accepts reports, diffs them against the stored report, builds event masks
// ---------------------------------------------------------------------------
module hkd_front (
   input  logic                      clock,
   input  logic                      reset,
   hkd_req_if.sink                   req,
   input  hkd_pkg::hkd_fifo_stat_type fifo_stat,
   output logic                      push,
   output hkd_pkg::hkd_entry_type    push_entry
);
   import hkd_pkg::*;

   logic [7:0]             prior_mods_ff;
   logic [7:0]             prior_mods_in;
   slot_row_type           prior_slots_ff;
   slot_row_type           prior_slots_in;
   slot_row_type           fresh;
   logic [7:0]             diff;
   logic [EVENT_COUNT-1:0] mask;
   logic                   accept;
   logic                   good_len;
   logic                   found;

   assign req.ready = !fifo_stat.full;
   assign accept    = req.valid && req.ready;
   assign good_len  = (req.report_length == REPORT_BYTES);

   assign fresh = {req.slot_5, req.slot_4, req.slot_3,
                   req.slot_2, req.slot_1, req.slot_0};
   assign diff  = req.modifier_bits ^ prior_mods_ff;

   always_comb begin
      mask = '0;
      for (int j = 0; j < MOD_COUNT; j++) begin
         mask[j] = diff[MOD_ORDER[j]];
      end
      // releases: stored keys missing from the new report
      for (int i = 0; i < SLOT_COUNT; i++) begin
         found = 1'b0;
         for (int k = 0; k < SLOT_COUNT; k++) begin
            found = found | (prior_slots_ff[i] == fresh[k]);
         end
         mask[REL_BASE+i] = (prior_slots_ff[i] >= MIN_KEY_CODE) && !found;
      end
      // presses: new keys missing from the stored report
      for (int i = 0; i < SLOT_COUNT; i++) begin
         found = 1'b0;
         for (int k = 0; k < SLOT_COUNT; k++) begin
            found = found | (fresh[i] == prior_slots_ff[k]);
         end
         mask[PRS_BASE+i] = (fresh[i] >= MIN_KEY_CODE) && !found;
      end
   end

   assign push                 = accept && good_len && (mask != '0);
   assign push_entry.mask      = mask;
   assign push_entry.mods      = req.modifier_bits;
   assign push_entry.old_slots = prior_slots_ff;
   assign push_entry.new_slots = fresh;

   always_comb begin
      prior_mods_in  = prior_mods_ff;
      prior_slots_in = prior_slots_ff;
      if (accept && good_len) begin
         prior_mods_in  = req.modifier_bits;
         prior_slots_in = fresh;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prior_mods_ff  <= '0;
         prior_slots_ff <= '0;
      end else begin
         prior_mods_ff  <= prior_mods_in;
         prior_slots_ff <= prior_slots_in;
      end
   end

endmodule

/* src/hkd_fifo.sv */
// ---------------------------------------------------------------------------
// hkd_fifo
// short queue of pending report diffs between front and back
// ---------------------------------------------------------------------------
module hkd_fifo (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  hkd_pkg::hkd_entry_type     push_entry,
   input  logic                       pop,
   output hkd_pkg::hkd_entry_type     head,
   output hkd_pkg::hkd_fifo_stat_type stat
);
   import hkd_pkg::*;

   hkd_entry_type         entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff;
   logic [FIFO_PTR_W-1:0] wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff;
   logic [FIFO_PTR_W-1:0] rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff;
   logic [FIFO_CNT_W-1:0] count_in;
   logic                  do_push;
   logic                  do_pop;

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* src/hkd_back.sv */
// ---------------------------------------------------------------------------
// hkd_back
// walks the event mask of the queue head, one event per cycle while rsp is not stalled
// ---------------------------------------------------------------------------
module hkd_back (
   input  logic                       clock,
   input  logic                       reset,
   input  hkd_pkg::hkd_entry_type     head,
   input  hkd_pkg::hkd_fifo_stat_type fifo_stat,
   output logic                       pop,
   hkd_rsp_if.source                  rsp
);
   import hkd_pkg::*;

   logic [EVENT_COUNT-1:0] done_ff;
   logic [EVENT_COUNT-1:0] done_in;
   logic                   valid_ff;
   logic                   valid_in;
   logic                   is_mod_ff;
   logic                   is_mod_in;
   logic [7:0]             code_ff;
   logic [7:0]             code_in;
   logic                   pressed_ff;
   logic                   pressed_in;
   logic                   last_ff;
   logic                   last_in;
   logic [EVENT_COUNT-1:0] remain;
   logic [EVENT_COUNT-1:0] pick;
   logic [EVENT_COUNT-1:0] rest;
   logic                   cand_mod [EVENT_COUNT];
   logic [7:0]             cand_code [EVENT_COUNT];
   logic                   cand_prs [EVENT_COUNT];
   logic                   emit;
   logic                   sel_mod;
   logic [7:0]             sel_code;
   logic                   sel_prs;

   assign remain = head.mask & ~done_ff;
   assign pick   = remain & (~remain + 1'b1);
   assign rest   = remain & ~pick;
   assign emit   = !fifo_stat.empty && (!valid_ff || rsp.ready);
   assign pop    = emit && (rest == '0);

   always_comb begin
      for (int j = 0; j < MOD_COUNT; j++) begin
         cand_mod[j]  = 1'b1;
         cand_code[j] = {5'd0, MOD_ORDER[j]};
         cand_prs[j]  = head.mods[MOD_ORDER[j]];
      end
      for (int i = 0; i < SLOT_COUNT; i++) begin
         cand_mod[REL_BASE+i]  = 1'b0;
         cand_code[REL_BASE+i] = head.old_slots[i];
         cand_prs[REL_BASE+i]  = 1'b0;
         cand_mod[PRS_BASE+i]  = 1'b0;
         cand_code[PRS_BASE+i] = head.new_slots[i];
         cand_prs[PRS_BASE+i]  = 1'b1;
      end
   end

   always_comb begin
      sel_mod  = 1'b0;
      sel_code = '0;
      sel_prs  = 1'b0;
      for (int k = 0; k < EVENT_COUNT; k++) begin
         sel_mod  = sel_mod | (pick[k] & cand_mod[k]);
         sel_code = sel_code | ({8{pick[k]}} & cand_code[k]);
         sel_prs  = sel_prs | (pick[k] & cand_prs[k]);
      end
   end

   always_comb begin
      done_in    = done_ff;
      valid_in   = valid_ff;
      is_mod_in  = is_mod_ff;
      code_in    = code_ff;
      pressed_in = pressed_ff;
      last_in    = last_ff;
      if (emit) begin
         valid_in   = 1'b1;
         is_mod_in  = sel_mod;
         code_in    = sel_code;
         pressed_in = sel_prs;
         last_in    = (rest == '0);
         done_in    = (rest == '0) ? '0 : (done_ff | pick);
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         done_ff  <= done_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_mod_ff  <= is_mod_in;
      code_ff    <= code_in;
      pressed_ff <= pressed_in;
      last_ff    <= last_in;
   end

   assign rsp.valid       = valid_ff;
   assign rsp.is_modifier = is_mod_ff;
   assign rsp.event_code  = code_ff;
   assign rsp.pressed     = pressed_ff;
   assign rsp.last_event  = last_ff;

endmodule

/* src/hid_report_key_event_differ_unit.sv */
// ---------------------------------------------------------------------------
// hid_report_key_event_differ_unit
// boot keyboard report differ: modifier, release and press events
// ---------------------------------------------------------------------------
//  channel  direction  handshake    payload
//  req      in         valid/ready  report_length, modifier_bits, slot_0..5
//  rsp      out        valid/ready  is_modifier, event_code, pressed, last_event
//
//  a report is taken every cycle while the two-entry queue has room
//  each report yields 0 to 20 events, one per cycle from the event register while rsp is not stalled
//  the back emits one event per cycle from the queue head while rsp is not stalled;
//  reports with no events are not queued
//  reset clears the stored report, the queue and the valid bit of the event register
//  a stalled rsp holds its event; the front keeps going until the queue fills
// ---------------------------------------------------------------------------
module hid_report_key_event_differ_unit (
   input  logic      clock,
   input  logic      reset,
   hkd_req_if.sink   req,
   hkd_rsp_if.source rsp
);
   import hkd_pkg::*;

   hkd_entry_type     push_entry;
   hkd_entry_type     head;
   hkd_fifo_stat_type fifo_stat;
   logic              push;
   logic              pop;

   hkd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .fifo_stat  (fifo_stat),
      .push       (push),
      .push_entry (push_entry)
   );

   hkd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .stat       (fifo_stat)
   );

   hkd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .fifo_stat (fifo_stat),
      .pop       (pop),
      .rsp       (rsp)
   );

endmodule

/* src/hkd_checker.sv */
// ---------------------------------------------------------------------------
// hkd_checker
// port-level checks on the event channel of the report differ
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hkd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_is_modifier,
   input logic [7:0] rsp_event_code,
   input logic       rsp_pressed,
   input logic       rsp_last_event
);
   import hkd_pkg::*;

   `HKD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_event_code) && $stable(rsp_pressed) && $stable(rsp_last_event))
   `HKD_ASSERT_IMPLY(a_mod_code, clock, reset, rsp_valid && rsp_is_modifier, rsp_event_code < 8'(MOD_COUNT))
   `HKD_ASSERT_IMPLY(a_key_code, clock, reset, rsp_valid && !rsp_is_modifier, rsp_event_code >= MIN_KEY_CODE)
   `HKD_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid)

endmodule

bind hid_report_key_event_differ_unit hkd_checker u_hkd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_is_modifier (rsp.is_modifier),
   .rsp_event_code  (rsp.event_code),
   .rsp_pressed     (rsp.pressed),
   .rsp_last_event  (rsp.last_event)
);

/* tb/tb.sv */
// ---------------------------------------------------------------------------
// tb
// checks the boot keyboard report differ against a transaction-level predictor
// reports go in through a queue-fed driver, and a monitor compares every event
// with the oldest predicted one; the sender pauses and the receiver stalls in
// random bursts
// ---------------------------------------------------------------------------
module tb;
   import hkd_pkg::*;

   localparam int HALF_PERIOD    = 4;
   localparam int RANDOM_REPORTS = 415;
   localparam int CALM_REPORTS   = 50;
   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 5000;

   typedef struct {
      logic [6:0]   len;
      logic [7:0]   mods;
      slot_row_type slots;
      int           gap;
      bit           drain_first;
      int           stall_pct;
   } report_type;

   typedef struct packed {
      logic       is_modifier;
      logic [7:0] event_code;
      logic       pressed;
      logic       last_event;
   } key_event_type;

   logic clock;
   logic reset;

   hkd_req_if req_ch ();
   hkd_rsp_if rsp_ch ();

   hid_report_key_event_differ_unit i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   report_type    queued_reports [$];
   key_event_type awaited_events [$];
   logic [7:0]    held_mods;
   slot_row_type  held_slots;
   int            fail_count;
   int            checked_count;
   int            quiet_cycles;
   int            idle_left;
   bit            gap_loaded;
   int            stall_left;
   int            sink_stall_pct;

   always #HALF_PERIOD clock = ~clock;

   task automatic report_mismatch(string msg);
      $display("ERROR: %s", msg);
      fail_count++;
   endtask

   function automatic bit slot_holds(slot_row_type slots, logic [7:0] code);
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (slots[i] == code) return 1'b1;
      end
      return 1'b0;
   endfunction

   // events for one accepted report, in modifier / release / press order
   function automatic void diff_report(report_type r);
      key_event_type events [$];
      key_event_type ev;
      logic [7:0]    flips;
      logic [2:0]    bit_idx;
      if (r.len != REPORT_BYTES) return;
      flips = r.mods ^ held_mods;
      for (int i = 0; i < MOD_COUNT; i++) begin
         bit_idx = MOD_ORDER[i];
         if (flips[bit_idx]) begin
            ev = '{1'b1, {5'd0, bit_idx}, r.mods[bit_idx], 1'b0};
            events.push_back(ev);
         end
      end
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (held_slots[i] >= MIN_KEY_CODE && !slot_holds(r.slots, held_slots[i])) begin
            ev = '{1'b0, held_slots[i], 1'b0, 1'b0};
            events.push_back(ev);
         end
      end
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (r.slots[i] >= MIN_KEY_CODE && !slot_holds(held_slots, r.slots[i])) begin
            ev = '{1'b0, r.slots[i], 1'b1, 1'b0};
            events.push_back(ev);
         end
      end
      if (events.size() > 0) events[events.size()-1].last_event = 1'b1;
      foreach (events[i]) awaited_events.push_back(events[i]);
      held_mods  = r.mods;
      held_slots = r.slots;
   endfunction

   function automatic slot_row_type row(int s0, int s1, int s2, int s3, int s4, int s5);
      slot_row_type r;
      r[0] = 8'(s0);
      r[1] = 8'(s1);
      r[2] = 8'(s2);
      r[3] = 8'(s3);
      r[4] = 8'(s4);
      r[5] = 8'(s5);
      return r;
   endfunction

   function automatic slot_row_type random_row();
      slot_row_type r;
      for (int i = 0; i < SLOT_COUNT; i++) r[i] = 8'($urandom_range(0, 255));
      return r;
   endfunction

   // mostly a small pool so keys recur across reports
   function automatic logic [7:0] pick_code();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 6) return 8'($urandom_range(4, 12));
      if (sel < 8) return 8'($urandom_range(0, 3));
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic void queue_report(logic [6:0] len, logic [7:0] mods, slot_row_type slots,
                                        int gap, bit drain_first, int stall_pct);
      report_type r;
      r.len         = len;
      r.mods        = mods;
      r.slots       = slots;
      r.gap         = gap;
      r.drain_first = drain_first;
      r.stall_pct   = stall_pct;
      queued_reports.push_back(r);
   endfunction

   // driver
   always @(posedge clock) begin
      bit show;
      show = 1'b0;
      if (reset) begin
         req_ch.valid <= 1'b0;
         gap_loaded = 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            sink_stall_pct <= queued_reports[0].stall_pct;
            diff_report(queued_reports.pop_front());
            gap_loaded = 1'b0;
         end else if (req_ch.valid) begin
            show = 1'b1;
         end
         if (!show && queued_reports.size() > 0) begin
            if (!gap_loaded) begin
               idle_left  = queued_reports[0].gap;
               gap_loaded = 1'b1;
            end
            if (idle_left > 0) begin
               idle_left--;
            end else if (!queued_reports[0].drain_first || awaited_events.size() == 0) begin
               show = 1'b1;
            end
         end
         req_ch.valid <= show;
         if (show) begin
            req_ch.report_length <= queued_reports[0].len;
            req_ch.modifier_bits <= queued_reports[0].mods;
            req_ch.slot_0        <= queued_reports[0].slots[0];
            req_ch.slot_1        <= queued_reports[0].slots[1];
            req_ch.slot_2        <= queued_reports[0].slots[2];
            req_ch.slot_3        <= queued_reports[0].slots[3];
            req_ch.slot_4        <= queued_reports[0].slots[4];
            req_ch.slot_5        <= queued_reports[0].slots[5];
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      key_event_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_events.size() == 0) begin
               report_mismatch($sformatf("event %0d: unexpected, code %0d",
                                         checked_count, rsp_ch.event_code));
            end else begin
               want = awaited_events.pop_front();
               if (rsp_ch.is_modifier !== want.is_modifier)
                  report_mismatch($sformatf("event %0d: is_modifier %b, expected %b",
                                            checked_count, rsp_ch.is_modifier, want.is_modifier));
               if (rsp_ch.event_code !== want.event_code)
                  report_mismatch($sformatf("event %0d: event_code %0d, expected %0d",
                                            checked_count, rsp_ch.event_code, want.event_code));
               if (rsp_ch.pressed !== want.pressed)
                  report_mismatch($sformatf("event %0d: pressed %b, expected %b",
                                            checked_count, rsp_ch.pressed, want.pressed));
               if (rsp_ch.last_event !== want.last_event)
                  report_mismatch($sformatf("event %0d: last_event %b, expected %b",
                                            checked_count, rsp_ch.last_event, want.last_event));
            end
            checked_count++;
         end
         if (stall_left > 0) begin
            stall_left--;
         end else if ($urandom_range(0, 99) < sink_stall_pct) begin
            stall_left = $urandom_range(1, 18);
         end
         rsp_ch.ready <= (stall_left == 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL hid_report_key_event_differ_unit");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [7:0]   gen_mods;
      slot_row_type gen_slots;
      logic [6:0]   len;
      int           good_count;
      int           n;
      int           phase;
      int           kind;
      int           gap_pct;
      int           stall_pct;
      bit           calm;

      clock                = 1'b0;
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.report_length = '0;
      req_ch.modifier_bits = '0;
      req_ch.slot_0        = '0;
      req_ch.slot_1        = '0;
      req_ch.slot_2        = '0;
      req_ch.slot_3        = '0;
      req_ch.slot_4        = '0;
      req_ch.slot_5        = '0;
      rsp_ch.ready         = 1'b0;
      held_mods            = '0;
      held_slots           = '0;
      fail_count           = 0;
      checked_count        = 0;
      quiet_cycles         = 0;
      idle_left            = 0;
      gap_loaded           = 1'b0;
      stall_left           = 0;
      sink_stall_pct       = 0;

      // directed reports
      queue_report(REPORT_BYTES, 8'h00, row(0, 0, 0, 0, 0, 0), 0, 1'b0, 0);
      queue_report(REPORT_BYTES, 8'hff, row(4, 5, 6, 7, 8, 9), 0, 1'b0, 0);
      queue_report(REPORT_BYTES, 8'h00, row(0, 0, 0, 0, 0, 0), 0, 1'b0, 0);
      queue_report(REPORT_BYTES, 8'h00, row(4, 5, 6, 7, 8, 9), 0, 1'b0, 20);
      queue_report(REPORT_BYTES, 8'hff, row(250, 251, 252, 253, 254, 255), 0, 1'b1, 20);
      queue_report(7'd0, 8'($urandom_range(0, 255)), random_row(), 0, 1'b0, 0);
      queue_report(7'd7, 8'($urandom_range(0, 255)), random_row(), 0, 1'b0, 0);
      queue_report(7'd9, 8'($urandom_range(0, 255)), random_row(), 0, 1'b0, 0);
      queue_report(7'd64, 8'($urandom_range(0, 255)), random_row(), 0, 1'b0, 0);
      queue_report(7'd127, 8'($urandom_range(0, 255)), random_row(), 0, 1'b0, 0);
      queue_report(REPORT_BYTES, 8'h55, row(250, 251, 252, 253, 254, 255), 0, 1'b0, 0);
      queue_report(REPORT_BYTES, 8'haa, row(255, 254, 253, 252, 251, 250), 0, 1'b0, 0);
      queue_report(REPORT_BYTES, 8'h00, row(5, 5, 5, 0, 1, 2), 0, 1'b0, 0);
      queue_report(REPORT_BYTES, 8'h00, row(0, 1, 2, 3, 3, 0), 0, 1'b0, 0);
      queue_report(REPORT_BYTES, 8'h00, row(0, 1, 2, 3, 3, 0), 0, 1'b0, 0);
      queue_report(REPORT_BYTES, 8'h01, row(3, 4, 3, 4, 0, 0), 0, 1'b0, 0);
      queue_report(REPORT_BYTES, 8'h01, row(0, 0, 0, 0, 4, 0), 0, 1'b0, 0);
      queue_report(REPORT_BYTES, 8'h80, row(4, 0, 0, 0, 0, 0), 0, 1'b0, 0);

      // random reports, mostly small edits of the previous well-formed one
      gen_mods   = 8'h80;
      gen_slots  = row(4, 0, 0, 0, 0, 0);
      good_count = 0;
      n          = 0;
      while (good_count < RANDOM_REPORTS) begin
         phase     = n / 50;
         calm      = (RANDOM_REPORTS - good_count) <= CALM_REPORTS;
         gap_pct   = calm ? 0 : (phase % 3 == 0 ? 0 : (phase % 3 == 1 ? 15 : 40));
         stall_pct = calm ? 0 : ((phase + 1) % 3 == 0 ? 0 : ((phase + 1) % 3 == 1 ? 10 : 35));
         kind      = $urandom_range(0, 99);
         if (kind < 8) begin
            do len = 7'($urandom_range(0, 127)); while (len == REPORT_BYTES);
            queue_report(len, 8'($urandom_range(0, 255)), random_row(),
                         ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 18) : 0,
                         1'b0, stall_pct);
         end else begin
            if (kind < 18) begin
               gen_mods  = 8'($urandom_range(0, 255));
               gen_slots = random_row();
            end else begin
               if ($urandom_range(0, 3) == 0) gen_mods = 8'($urandom_range(0, 255));
               else if ($urandom_range(0, 1) == 0) gen_mods[3'($urandom_range(0, 7))] ^= 1'b1;
               for (int i = 0; i < SLOT_COUNT; i++) begin
                  if ($urandom_range(0, 9) < 3) gen_slots[i] = pick_code();
               end
            end
            queue_report(REPORT_BYTES, gen_mods, gen_slots,
                         ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 18) : 0,
                         (n == 0) || (!calm && $urandom_range(0, 59) == 0), stall_pct);
            good_count++;
         end
         n++;
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (queued_reports.size() > 0 || awaited_events.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("PASS hid_report_key_event_differ_unit");
      end else begin
         $display("FAIL hid_report_key_event_differ_unit");
      end
      $finish;
   end

endmodule
